[src/buffer_slot_manager_defines.svh]
// ----------------------------------------------------------------------------
// Buffer slot manager assertion macros
// Shared property wrappers for the checker.
// ----------------------------------------------------------------------------
`ifndef BUFFER_SLOT_MANAGER_DEFINES_SVH
`define BUFFER_SLOT_MANAGER_DEFINES_SVH

// Clocked property, off while reset is asserted.
`define BSM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked property that also holds across reset.
`define BSM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/bsm_pkg.sv]
// ----------------------------------------------------------------------------
// Buffer slot manager package
// Request and status codes, slot record types and field widths.
// ----------------------------------------------------------------------------
package bsm_pkg;

    localparam int SLOTS_DEF = 16;

    localparam int OP_W    = 3;
    localparam int IDX_W   = 4;
    localparam int STAMP_W = 32;
    localparam int STS_W   = 2;
    localparam int CFG_W   = 5;
    localparam int IN_W    = 40;  // 39 bits of fields, padded to 5 bytes
    localparam int OUT_W   = 8;   // 7 bits of fields, padded to 1 byte

    localparam logic [CFG_W-1:0]   CFG_RESET = 5'd16;
    localparam logic [STAMP_W-1:0] TIME_MAX  = 32'hFFFF_FFFF;

    // request codes
    localparam logic [OP_W-1:0] OP_ALLOC   = 3'd0;
    localparam logic [OP_W-1:0] OP_MARK    = 3'd1;
    localparam logic [OP_W-1:0] OP_OLDEST  = 3'd2;
    localparam logic [OP_W-1:0] OP_NEWEST  = 3'd3;
    localparam logic [OP_W-1:0] OP_RELEASE = 3'd4;
    localparam logic [OP_W-1:0] OP_PURGE   = 3'd5;

    // slot states
    localparam logic [1:0] SLOT_EMPTY  = 2'd0;
    localparam logic [1:0] SLOT_FILLED = 2'd1;
    localparam logic [1:0] SLOT_LOCKED = 2'd2;

    // result status codes
    localparam logic [STS_W-1:0] RS_OK   = 2'd0;
    localparam logic [STS_W-1:0] RS_NONE = 2'd1;
    localparam logic [STS_W-1:0] RS_BUSY = 2'd2;

    typedef struct packed {
        logic [1:0]         st;
        logic [STAMP_W-1:0] stamp;
    } t_rec;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

    typedef struct packed {
        logic fe_found;      // an active empty slot was seen
        logic best_found;    // a filled slot beat the running best
        logic hint_empty;    // hinted slot is active and empty
        logic slot0_locked;  // slot 0 is locked
    } t_scan_flags;

endpackage

[src/bsm_cell.sv]
// ----------------------------------------------------------------------------
// Buffer slot cell
// Holds one slot record; rotates to its neighbor, takes a direct write or clears to empty.
// ----------------------------------------------------------------------------
module bsm_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bsm_pkg::t_cell_ctl i_ctl,
    input  logic              i_wr,
    input  bsm_pkg::t_rec     i_wr_rec,
    input  bsm_pkg::t_rec     i_next,
    output bsm_pkg::t_rec     o_rec
);
    import bsm_pkg::*;

    logic [1:0]         r_st;
    logic [STAMP_W-1:0] r_stamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= SLOT_EMPTY;
        end else if (i_ctl.clear) begin
            r_st <= SLOT_EMPTY;
        end else if (i_wr) begin
            r_st <= i_wr_rec.st;
        end else if (i_ctl.shift) begin
            r_st <= i_next.st;
        end
    end

    // stamp of an empty slot is never compared
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_stamp <= '0;
        end else if (i_wr) begin
            r_stamp <= i_wr_rec.stamp;
        end else if (i_ctl.shift) begin
            r_stamp <= i_next.stamp;
        end
    end

    assign o_rec = '{st: r_st, stamp: r_stamp};

endmodule

[src/bsm_scan.sv]
// ----------------------------------------------------------------------------
// Buffer slot scan unit
// Looks at the ring head once per cycle while stepping: first empty, oldest or newest.
// ----------------------------------------------------------------------------
module bsm_scan #(
    parameter  int SLOTS = bsm_pkg::SLOTS_DEF,
    localparam int CW    = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int KW0   = $clog2(SLOTS + 1),
    localparam int KW    = (KW0 > bsm_pkg::CFG_W) ? KW0 : bsm_pkg::CFG_W
) (
    input  logic                     i_clk,
    input  logic                     i_init,
    input  logic                     i_newest,
    input  logic                     i_step,
    input  bsm_pkg::t_rec            i_rec,
    input  logic [KW-1:0]            i_k,
    input  logic [KW-1:0]            i_n,
    input  logic [bsm_pkg::IDX_W-1:0] i_hint_slot,
    output bsm_pkg::t_scan_flags     o_flags,
    output logic [CW-1:0]            o_fe_idx,
    output logic [CW-1:0]            o_best_idx,
    output logic [bsm_pkg::STAMP_W-1:0] o_best_time
);
    import bsm_pkg::*;

    t_scan_flags        r_flags;
    logic [CW-1:0]      r_fe_idx;
    logic [CW-1:0]      r_best_idx;
    logic [STAMP_W-1:0] r_best_time;
    logic               r_newest;

    logic w_active;
    logic w_better;

    assign w_active = (i_k < i_n);
    assign w_better = r_newest ? (i_rec.stamp > r_best_time)
                               : (i_rec.stamp < r_best_time);

    always_ff @(posedge i_clk) begin
        if (i_init) begin
            r_flags     <= '0;
            r_fe_idx    <= '0;
            r_best_idx  <= '0;
            r_best_time <= i_newest ? '0 : TIME_MAX;
            r_newest    <= i_newest;
        end else if (i_step) begin
            if (w_active && i_rec.st == SLOT_EMPTY && !r_flags.fe_found) begin
                r_flags.fe_found <= 1'b1;
                r_fe_idx         <= CW'(i_k);
            end
            if (w_active && i_k == KW'(i_hint_slot)) begin
                r_flags.hint_empty <= (i_rec.st == SLOT_EMPTY);
            end
            if (i_k == '0) begin
                r_flags.slot0_locked <= (i_rec.st == SLOT_LOCKED);
            end
            // strict compare, lowest index keeps a tie
            if (w_active && i_rec.st == SLOT_FILLED && w_better) begin
                r_flags.best_found <= 1'b1;
                r_best_idx         <= CW'(i_k);
                r_best_time        <= i_rec.stamp;
            end
        end
    end

    assign o_flags     = r_flags;
    assign o_fe_idx    = r_fe_idx;
    assign o_best_idx  = r_best_idx;
    assign o_best_time = r_best_time;

endmodule

[src/buffer_slot_manager.sv]
// ----------------------------------------------------------------------------
// Buffer slot manager
// Slot pool with allocate, mark, take oldest/newest, release and purge.
// ----------------------------------------------------------------------------
// Allocate, take-oldest and take-newest: the request goes through the scan
// state (the slot ring rotates one cell per cycle past the scan unit) and
// then the finish step, which registers the result beat and returns to idle.
// Mark, release, purge and unused codes go straight to the finish step.
// One request in flight; an untaken result holds the next request in its
// finish step. Reset empties every slot; slots_in_use -> 16.
// ----------------------------------------------------------------------------
module buffer_slot_manager #(
    parameter int SLOTS = bsm_pkg::SLOTS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // request beats: op [2:0], slot_index [6:3], stamp [38:7]
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [bsm_pkg::IN_W-1:0]  i_s_tdata,
    // result beats: result_slot [3:0], status [5:4], evicted [6]
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [bsm_pkg::OUT_W-1:0] o_m_tdata,
    // slots_in_use register write
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [bsm_pkg::CFG_W-1:0] i_cfg_data
);
    import bsm_pkg::*;

    localparam int CW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int KW0 = $clog2(SLOTS + 1);
    localparam int KW  = (KW0 > CFG_W) ? KW0 : CFG_W;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} t_state;

    t_state             r_state;
    logic [CW-1:0]      r_cnt;
    logic [OP_W-1:0]    r_op;
    logic [IDX_W-1:0]   r_idx;
    logic [STAMP_W-1:0] r_stamp;
    logic [CFG_W-1:0]   r_cfg;
    logic               r_hint_valid;
    logic [IDX_W-1:0]   r_hint_slot;
    logic               r_o_valid;
    logic [OUT_W-1:0]   r_o_data;

    // ring of slot cells; cell 0 is the head seen by the scan unit
    t_rec       w_ring [SLOTS];
    t_cell_ctl  w_ctl;
    logic       w_wr_en;
    logic [KW-1:0] w_tgt;
    t_rec       w_wr_rec;

    // incoming beat fields
    logic [OP_W-1:0] w_in_op;
    logic            w_accept;
    logic            w_scan_op;

    // scan unit results
    t_scan_flags        w_flags;
    logic [CW-1:0]      w_fe_idx;
    logic [CW-1:0]      w_best_idx;
    logic [STAMP_W-1:0] w_best_time;

    // finish stage
    logic [KW-1:0]    w_n;
    logic             w_idx_ok;
    logic             w_fire;
    logic [IDX_W-1:0] w_res;
    logic [STS_W-1:0] w_status;
    logic             w_ev;
    logic             w_set_hint;

    assign w_in_op   = i_s_tdata[OP_W-1:0];
    assign w_accept  = i_s_tvalid && (r_state == S_IDLE);
    assign w_scan_op = (w_in_op == OP_ALLOC) || (w_in_op == OP_OLDEST) ||
                       (w_in_op == OP_NEWEST);

    // active count: 0 acts as 1, anything above SLOTS as SLOTS
    always_comb begin
        if (r_cfg == '0) begin
            w_n = KW'(1);
        end else if (KW'(r_cfg) > KW'(SLOTS)) begin
            w_n = KW'(SLOTS);
        end else begin
            w_n = KW'(r_cfg);
        end
    end

    assign w_idx_ok = (KW'(r_idx) < w_n);
    assign w_fire   = (r_state == S_FINISH) && (!r_o_valid || i_m_tready);

    genvar gi;
    generate
        for (gi = 0; gi < SLOTS; gi++) begin : g_cell
            logic w_wr_here;
            assign w_wr_here = w_wr_en && (w_tgt == KW'(gi));
            bsm_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctl    (w_ctl),
                .i_wr     (w_wr_here),
                .i_wr_rec (w_wr_rec),
                .i_next   (w_ring[(gi + 1) % SLOTS]),
                .o_rec    (w_ring[gi])
            );
        end
    endgenerate

    bsm_scan #(.SLOTS(SLOTS)) u_scan (
        .i_clk       (i_clk),
        .i_init      (w_accept),
        .i_newest    (w_in_op == OP_NEWEST),
        .i_step      (r_state == S_SCAN),
        .i_rec       (w_ring[0]),
        .i_k         (KW'(r_cnt)),
        .i_n         (w_n),
        .i_hint_slot (r_hint_slot),
        .o_flags     (w_flags),
        .o_fe_idx    (w_fe_idx),
        .o_best_idx  (w_best_idx),
        .o_best_time (w_best_time)
    );

    // Finish: after SLOTS shifts the ring is back in index order, so a
    // single slot update goes straight to its cell by index; purge clears all.
    always_comb begin
        w_ctl.shift = (r_state == S_SCAN);
        w_ctl.clear = 1'b0;
        w_wr_en     = 1'b0;
        w_tgt       = KW'(r_idx);
        w_wr_rec    = '{st: SLOT_EMPTY, stamp: '0};
        w_res       = '0;
        w_status    = RS_OK;
        w_ev        = 1'b0;
        w_set_hint  = 1'b0;
        case (r_op)
            OP_ALLOC: begin
                if (r_hint_valid && w_flags.hint_empty) begin
                    w_res = r_hint_slot;
                end else if (w_flags.fe_found) begin
                    w_res = IDX_W'(w_fe_idx);
                end else if (w_flags.best_found) begin
                    // victim is filled: evict it
                    w_res   = IDX_W'(w_best_idx);
                    w_tgt   = KW'(w_best_idx);
                    w_wr_en = w_fire;
                    w_ev    = 1'b1;
                end else if (w_flags.slot0_locked) begin
                    w_status = RS_BUSY;
                end else begin
                    // no stamp beat the start value: slot 0 goes
                    w_tgt   = '0;
                    w_wr_en = w_fire;
                    w_ev    = 1'b1;
                end
            end
            OP_MARK: begin
                w_wr_en  = w_fire && w_idx_ok;
                w_wr_rec = '{st: SLOT_FILLED, stamp: r_stamp};
            end
            OP_OLDEST, OP_NEWEST: begin
                if (w_flags.best_found) begin
                    w_res    = IDX_W'(w_best_idx);
                    w_tgt    = KW'(w_best_idx);
                    w_wr_en  = w_fire;
                    w_wr_rec = '{st: SLOT_LOCKED, stamp: w_best_time};
                end else begin
                    w_status = RS_NONE;
                end
            end
            OP_RELEASE: begin
                w_wr_en    = w_fire && w_idx_ok;
                w_set_hint = w_idx_ok;
            end
            OP_PURGE: begin
                w_ctl.clear = w_fire;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_cfg        <= CFG_RESET;
            r_hint_valid <= 1'b0;
            r_hint_slot  <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cfg <= i_cfg_data;
            end
            // a new beat replaces one leaving in the same cycle
            if (w_fire) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && i_m_tready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op    <= w_in_op;
                        r_idx   <= i_s_tdata[OP_W +: IDX_W];
                        r_stamp <= i_s_tdata[OP_W + IDX_W +: STAMP_W];
                        r_cnt   <= '0;
                        r_state <= w_scan_op ? S_SCAN : S_FINISH;
                    end
                end
                S_SCAN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(SLOTS - 1)) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (w_fire) begin
                        r_o_data  <= {1'b0, w_ev, w_status, w_res};
                        if (r_op == OP_ALLOC) begin
                            r_hint_valid <= 1'b0;
                        end
                        if (w_set_hint) begin
                            r_hint_valid <= 1'b1;
                            r_hint_slot  <= r_idx;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_o_valid;
    assign o_m_tdata   = r_o_data;
    assign o_cfg_ready = 1'b1;

endmodule

[src/bsm_checker.sv]
// ----------------------------------------------------------------------------
// Buffer slot manager checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "buffer_slot_manager_defines.svh"

module bsm_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_m_tvalid,
    input logic                      i_m_tready,
    input logic [bsm_pkg::OUT_W-1:0] o_m_tdata
);
    import bsm_pkg::*;

    `BSM_ASSERT(a_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata), "result beat changed while stalled")
    `BSM_ASSERT(a_status_code, i_clk, i_rst_n, o_m_tvalid |-> o_m_tdata[5:4] != 2'd3, "undefined status code")
    `BSM_ASSERT(a_evict_ok, i_clk, i_rst_n, o_m_tvalid && o_m_tdata[6] |-> o_m_tdata[5:4] == RS_OK, "eviction with non-ok status")
    `BSM_ASSERT(a_none_slot0, i_clk, i_rst_n, o_m_tvalid && o_m_tdata[5:4] == RS_NONE |-> o_m_tdata[3:0] == 4'd0 && !o_m_tdata[6], "not-found result carries a slot")
    `BSM_ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> !o_m_tvalid, "result valid after reset")

endmodule

bind buffer_slot_manager bsm_checker u_bsm_checker (.*);
